// ----- design/tlms_pkg.sv -----
// Package with the shared types and constants of the two-list merge sorter.
`default_nettype none

package tlms_pkg;

   localparam int WORD_WIDTH     = 32;
   localparam int CMD_WIDTH      = 2;
   localparam int MODE_WIDTH     = 2;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CMD_WIDTH-1:0] CMD_APPEND_FIRST  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_APPEND_SECOND = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ          = 2'd2;

   localparam logic [MODE_WIDTH-1:0] MODE_FIRST_SECOND = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SECOND_FIRST = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_ASCENDING    = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DESCENDING   = 2'd3;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MODE_ADDR = 3'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY_CHECK,
      ST_COPY_MOVE,
      ST_SORT_NEXT,
      ST_SORT_LOAD,
      ST_SORT_CHECK,
      ST_SORT_CMP,
      ST_SORT_PLACE,
      ST_READ_ISSUE,
      ST_READ_EMIT,
      ST_EMPTY_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RD_POSITION,
      RD_SORT_I,
      RD_SORT_J
   } rd_sel_type;

   typedef struct packed {
      logic       append_first;
      logic       append_second;
      logic       copy_reset;
      logic       copy_next_seg;
      logic       copy_move;
      logic       sort_start;
      logic       sort_load;
      logic       sort_shift;
      logic       sort_place;
      logic       finish_arrange;
      logic       emit_word;
      logic       emit_empty;
      rd_sel_type rd_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic copy_done;
      logic copy_seg;
      logic sort_wanted;
      logic sort_done;
      logic j_zero;
      logic goes_first;
      logic total_zero;
      logic arranged;
      logic out_free;
   } ctl_status_type;

endpackage

`default_nettype wire

// ----- design/tlms_if.sv -----
// Request and response channel interfaces of the two-list merge sorter.
`default_nettype none

interface tlms_req_if;
   logic                                        valid;
   logic                                        ready;
   logic        [tlms_pkg::CMD_WIDTH-1:0]       command;
   logic signed [tlms_pkg::WORD_WIDTH-1:0]      value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface tlms_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [tlms_pkg::WORD_WIDTH-1:0]      value_res;
   logic                                        is_last;
   logic                                        none_left;

   modport source (output valid, output value_res, output is_last, output none_left,
                   input ready);
   modport sink   (input valid, input value_res, input is_last, input none_left,
                   output ready);
endinterface

`default_nettype wire

// ----- design/two_list_merge_sorter.sv -----
// Two-list merge sorter: top level that joins the controller and the datapath.
//
// Requests on req_chan carry a command and a word. Append commands store the
// word at the end of the first or second list; appends to a full list, or
// made while a combined list is being read out, are dropped.
// A read command returns one response on rsp_chan. The first read of a data
// set arranges the lists into the result memory according to merge_mode: it
// copies the words of the lists in mode order, plus for the sorted modes it
// runs an insertion sort in the result memory that compares and moves one
// word at a time. Each following read loads its response in the emit step
// once the response register is free, before the next request can be taken.
// After the final word both lists are empty.
// One request is worked on at a time; a new request is taken once the response
// register is loaded, even while that response still waits for rsp_chan.ready.
// A stalled receiver holds the block in its response step. Reset clears the
// counts, the mode and the response valid bit; memory contents are not cleared.
// merge_mode sits at byte address 0 of the csr_ port.
`default_nettype none

module two_list_merge_sorter #(
   parameter int FIRST_DEPTH  = 1024,
   parameter int SECOND_DEPTH = 1024
) (
   input  wire                                   clock,
   input  wire                                   reset,
   tlms_req_if.sink                              req_chan,
   tlms_rsp_if.source                            rsp_chan,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire [tlms_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire [tlms_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [tlms_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   tlms_pkg::ctl_cmd_type    cmd;
   tlms_pkg::ctl_status_type status;
   logic                     req_ready;

   assign csr_pready     = 1'b1;
   assign req_chan.ready = req_ready;

   tlms_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   tlms_datapath #(
      .FIRST_DEPTH  (FIRST_DEPTH),
      .SECOND_DEPTH (SECOND_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_chan.value),
      .cmd         (cmd),
      .status      (status),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- design/tlms_controller.sv -----
// Controller state machine that sequences loading, arranging and reading out.
`default_nettype none

module tlms_controller (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire [tlms_pkg::CMD_WIDTH-1:0]    req_command,
   output logic                             req_ready,
   input  tlms_pkg::ctl_status_type         status,
   output tlms_pkg::ctl_cmd_type            cmd
);

   tlms_pkg::ctrl_state_type state_ff;
   tlms_pkg::ctrl_state_type state_in;
   logic                     accept;

   assign accept = req_valid && (state_ff == tlms_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlms_pkg::ST_IDLE: begin
            if (accept && req_command == tlms_pkg::CMD_READ) begin
               if (status.total_zero) begin
                  state_in = tlms_pkg::ST_EMPTY_EMIT;
               end else if (status.arranged) begin
                  state_in = tlms_pkg::ST_READ_EMIT;
               end else begin
                  state_in = tlms_pkg::ST_COPY_CHECK;
               end
            end
         end
         tlms_pkg::ST_COPY_CHECK: begin
            if (!status.copy_done) begin
               state_in = tlms_pkg::ST_COPY_MOVE;
            end else if (status.copy_seg) begin
               state_in = status.sort_wanted ? tlms_pkg::ST_SORT_NEXT
                                             : tlms_pkg::ST_READ_ISSUE;
            end
         end
         tlms_pkg::ST_COPY_MOVE: state_in = tlms_pkg::ST_COPY_CHECK;
         tlms_pkg::ST_SORT_NEXT: begin
            state_in = status.sort_done ? tlms_pkg::ST_READ_ISSUE : tlms_pkg::ST_SORT_LOAD;
         end
         tlms_pkg::ST_SORT_LOAD: state_in = tlms_pkg::ST_SORT_CHECK;
         tlms_pkg::ST_SORT_CHECK: begin
            state_in = status.j_zero ? tlms_pkg::ST_SORT_PLACE : tlms_pkg::ST_SORT_CMP;
         end
         tlms_pkg::ST_SORT_CMP: begin
            state_in = status.goes_first ? tlms_pkg::ST_SORT_CHECK : tlms_pkg::ST_SORT_PLACE;
         end
         tlms_pkg::ST_SORT_PLACE: state_in = tlms_pkg::ST_SORT_NEXT;
         tlms_pkg::ST_READ_ISSUE: state_in = tlms_pkg::ST_READ_EMIT;
         tlms_pkg::ST_READ_EMIT: begin
            if (status.out_free) begin
               state_in = tlms_pkg::ST_IDLE;
            end
         end
         tlms_pkg::ST_EMPTY_EMIT: begin
            if (status.out_free) begin
               state_in = tlms_pkg::ST_IDLE;
            end
         end
         default: state_in = tlms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = tlms_pkg::RD_POSITION;
      req_ready  = 1'b0;
      unique case (state_ff)
         tlms_pkg::ST_IDLE: begin
            req_ready         = 1'b1;
            cmd.append_first  = accept && req_command == tlms_pkg::CMD_APPEND_FIRST;
            cmd.append_second = accept && req_command == tlms_pkg::CMD_APPEND_SECOND;
            cmd.copy_reset    = accept && req_command == tlms_pkg::CMD_READ;
         end
         tlms_pkg::ST_COPY_CHECK: begin
            cmd.copy_next_seg  = status.copy_done && !status.copy_seg;
            cmd.sort_start     = status.copy_done && status.copy_seg && status.sort_wanted;
            cmd.finish_arrange = status.copy_done && status.copy_seg && !status.sort_wanted;
         end
         tlms_pkg::ST_COPY_MOVE: cmd.copy_move = 1'b1;
         tlms_pkg::ST_SORT_NEXT: begin
            cmd.rd_sel         = tlms_pkg::RD_SORT_I;
            cmd.finish_arrange = status.sort_done;
         end
         tlms_pkg::ST_SORT_LOAD: cmd.sort_load = 1'b1;
         tlms_pkg::ST_SORT_CHECK: cmd.rd_sel = tlms_pkg::RD_SORT_J;
         tlms_pkg::ST_SORT_CMP: cmd.sort_shift = status.goes_first;
         tlms_pkg::ST_SORT_PLACE: cmd.sort_place = 1'b1;
         tlms_pkg::ST_READ_ISSUE: cmd.rd_sel = tlms_pkg::RD_POSITION;
         tlms_pkg::ST_READ_EMIT: cmd.emit_word = status.out_free;
         tlms_pkg::ST_EMPTY_EMIT: cmd.emit_empty = status.out_free;
         default: cmd.rd_sel = tlms_pkg::RD_POSITION;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/tlms_datapath.sv -----
// Datapath with the list memories, counters, sort registers and response register.
`default_nettype none

module tlms_datapath #(
   parameter int FIRST_DEPTH  = 1024,
   parameter int SECOND_DEPTH = 1024
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire signed [tlms_pkg::WORD_WIDTH-1:0]   req_value,
   input  tlms_pkg::ctl_cmd_type                   cmd,
   output tlms_pkg::ctl_status_type                status,
   input  wire                                     csr_psel,
   input  wire                                     csr_penable,
   input  wire                                     csr_pwrite,
   input  wire [tlms_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  wire [tlms_pkg::CSR_DATA_WIDTH-1:0]      csr_pwdata,
   output logic [tlms_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   tlms_rsp_if.source                              rsp_chan
);

   localparam int TOTAL_DEPTH = FIRST_DEPTH + SECOND_DEPTH;
   localparam int FCW = $clog2(FIRST_DEPTH + 1);
   localparam int SCW = $clog2(SECOND_DEPTH + 1);
   localparam int TCW = $clog2(TOTAL_DEPTH + 1);
   localparam int FAW = $clog2(FIRST_DEPTH);
   localparam int SAW = $clog2(SECOND_DEPTH);
   localparam int TAW = $clog2(TOTAL_DEPTH);
   localparam int KW  = (FCW > SCW) ? FCW : SCW;
   localparam int WW  = tlms_pkg::WORD_WIDTH;

   logic [WW-1:0] first_mem  [0:FIRST_DEPTH-1];
   logic [WW-1:0] second_mem [0:SECOND_DEPTH-1];
   logic [WW-1:0] result_mem [0:TOTAL_DEPTH-1];

   logic [WW-1:0] first_rdata_ff;
   logic [WW-1:0] second_rdata_ff;
   logic [WW-1:0] result_rdata_ff;

   logic [tlms_pkg::MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [FCW-1:0] first_count_ff, first_count_in;
   logic [SCW-1:0] second_count_ff, second_count_in;
   logic [TAW-1:0] rp_ff, rp_in;
   logic           arranged_ff, arranged_in;
   logic [KW-1:0]  k_ff, k_in;
   logic           seg_ff, seg_in;
   logic [TCW-1:0] pos_ff, pos_in;
   logic [TCW-1:0] i_ff, i_in;
   logic [TCW-1:0] j_ff, j_in;
   logic [WW-1:0]  w_ff, w_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]  out_value_ff, out_value_in;
   logic           out_last_ff, out_last_in;
   logic           out_none_ff, out_none_in;

   logic [TCW-1:0] total;
   logic [TCW-1:0] rp_next;
   logic           is_last_word;
   logic           use_second;
   logic [KW-1:0]  src_count;
   logic [WW-1:0]  src_data;
   logic [TAW-1:0] res_raddr;
   logic           res_we;
   logic [TAW-1:0] res_waddr;
   logic [WW-1:0]  res_wdata;
   logic           first_we;
   logic           second_we;
   logic           csr_write;

   assign total        = TCW'(first_count_ff) + TCW'(second_count_ff);
   assign rp_next      = TCW'(rp_ff) + TCW'(1);
   assign is_last_word = (rp_next == total);
   assign use_second   = seg_ff ^ (mode_ff == tlms_pkg::MODE_SECOND_FIRST);
   assign src_count    = use_second ? KW'(second_count_ff) : KW'(first_count_ff);
   assign src_data     = use_second ? second_rdata_ff : first_rdata_ff;
   assign first_we     = cmd.append_first && !arranged_ff
                         && (first_count_ff < FCW'(FIRST_DEPTH));
   assign second_we    = cmd.append_second && !arranged_ff
                         && (second_count_ff < SCW'(SECOND_DEPTH));
   assign csr_write    = csr_psel && csr_penable && csr_pwrite
                         && (csr_paddr[2] == tlms_pkg::CSR_MODE_ADDR[2]);

   assign status.copy_done   = (k_ff == src_count);
   assign status.copy_seg    = seg_ff;
   assign status.sort_wanted = mode_ff[1];
   assign status.sort_done   = (i_ff >= total);
   assign status.j_zero      = (j_ff == '0);
   assign status.goes_first  = (mode_ff == tlms_pkg::MODE_DESCENDING)
                               ? ($signed(w_ff) > $signed(result_rdata_ff))
                               : ($signed(w_ff) < $signed(result_rdata_ff));
   assign status.total_zero  = (total == '0);
   assign status.arranged    = arranged_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_chan.ready;

   assign csr_prdata = (csr_paddr[2] == tlms_pkg::CSR_MODE_ADDR[2])
                       ? tlms_pkg::CSR_DATA_WIDTH'(mode_ff) : '0;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_res = out_value_ff;
   assign rsp_chan.is_last   = out_last_ff;
   assign rsp_chan.none_left = out_none_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         tlms_pkg::RD_POSITION: res_raddr = rp_ff;
         tlms_pkg::RD_SORT_I:   res_raddr = i_ff[TAW-1:0];
         tlms_pkg::RD_SORT_J:   res_raddr = TAW'(j_ff - TCW'(1));
         default:               res_raddr = rp_ff;
      endcase
   end

   always_comb begin
      res_we    = cmd.copy_move || cmd.sort_shift || cmd.sort_place;
      res_waddr = j_ff[TAW-1:0];
      res_wdata = w_ff;
      if (cmd.copy_move) begin
         res_waddr = pos_ff[TAW-1:0];
         res_wdata = src_data;
      end else if (cmd.sort_shift) begin
         res_wdata = result_rdata_ff;
      end
   end

   always_comb begin
      mode_in         = csr_write ? csr_pwdata[tlms_pkg::MODE_WIDTH-1:0] : mode_ff;
      first_count_in  = first_we ? first_count_ff + FCW'(1) : first_count_ff;
      second_count_in = second_we ? second_count_ff + SCW'(1) : second_count_ff;
      rp_in           = rp_ff;
      arranged_in     = arranged_ff;
      k_in            = k_ff;
      seg_in          = seg_ff;
      pos_in          = pos_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      w_in            = w_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;
      out_none_in     = out_none_ff;

      if (cmd.copy_reset) begin
         k_in   = '0;
         seg_in = 1'b0;
         pos_in = '0;
      end
      if (cmd.copy_next_seg) begin
         k_in   = '0;
         seg_in = 1'b1;
      end
      if (cmd.copy_move) begin
         k_in   = k_ff + KW'(1);
         pos_in = pos_ff + TCW'(1);
      end
      if (cmd.sort_start) begin
         i_in = TCW'(1);
      end
      if (cmd.sort_load) begin
         w_in = result_rdata_ff;
         j_in = i_ff;
      end
      if (cmd.sort_shift) begin
         j_in = j_ff - TCW'(1);
      end
      if (cmd.sort_place) begin
         i_in = i_ff + TCW'(1);
      end
      if (cmd.finish_arrange) begin
         arranged_in = 1'b1;
         rp_in       = '0;
      end
      if (cmd.emit_word) begin
         rsp_valid_in = 1'b1;
         out_value_in = result_rdata_ff;
         out_last_in  = is_last_word;
         out_none_in  = 1'b0;
         if (is_last_word) begin
            first_count_in  = '0;
            second_count_in = '0;
            rp_in           = '0;
            arranged_in     = 1'b0;
         end else begin
            rp_in = rp_next[TAW-1:0];
         end
      end
      if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         out_value_in = '0;
         out_last_in  = 1'b0;
         out_none_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[first_count_ff[FAW-1:0]] <= req_value;
      end
      first_rdata_ff <= first_mem[k_ff[FAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_mem[second_count_ff[SAW-1:0]] <= req_value;
      end
      second_rdata_ff <= second_mem[k_ff[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         result_mem[res_waddr] <= res_wdata;
      end
      result_rdata_ff <= result_mem[res_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= tlms_pkg::MODE_FIRST_SECOND;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         rp_ff           <= '0;
         arranged_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         rp_ff           <= rp_in;
         arranged_ff     <= arranged_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      seg_ff       <= seg_in;
      pos_ff       <= pos_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      w_ff         <= w_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_none_ff  <= out_none_in;
   end

`ifndef NO_ASSERTIONS
   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_word || cmd.emit_empty) |-> status.out_free)
      else $error("response loaded while the previous one is still pending");

   a_first_count_bound: assert property (@(posedge clock) disable iff (reset)
      first_count_ff <= FCW'(FIRST_DEPTH))
      else $error("first list count beyond its depth");

   a_counts_frozen: assert property (@(posedge clock) disable iff (reset)
      (arranged_ff && !cmd.emit_word) |=>
         ($stable(first_count_ff) && $stable(second_count_ff)))
      else $error("list counts changed during readout");

   a_empty_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_none_ff) |-> (out_value_ff == '0 && !out_last_ff))
      else $error("empty response carries a word or a last flag");
`endif

endmodule

`default_nettype wire
